FILE: rtl/bta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy tree allocator package
// Shared types, tree size, node state codes and result status codes.
// ----------------------------------------------------------------------------
package bta_pkg;

	// Deepest tree the allocator manages; the item fields are sized for it.
	localparam int MAX_LEVELS = 10;

	localparam logic [1:0] BLK_VACANT = 2'd0;
	localparam logic [1:0] BLK_TAKEN  = 2'd1;
	localparam logic [1:0] BLK_HALVED = 2'd2;
	localparam logic [1:0] BLK_PACKED = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_ZERO      = 3'd1;
	localparam logic [2:0] ST_NOMEM     = 3'd2;
	localparam logic [2:0] ST_BADHANDLE = 3'd3;
	localparam logic [2:0] ST_FREED     = 3'd4;
	localparam logic [2:0] ST_NOTALLOC  = 3'd5;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [10:0] request_size;
		logic [10:0] node_index;
	} bta_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [10:0] granted_node;
		logic [9:0]  block_offset;
		logic [10:0] block_units;
		logic [10:0] used_units;
		logic [10:0] peak_units;
	} bta_out_t;

endpackage

FILE: rtl/buddy_tree_allocator_unit.sv
`timescale 1ns / 1ps
// A rejected item goes from idle straight to the done state and then gives its result strobe.
// An allocation reads each node, writes both halves of each node split, climbs one level per
// step and reads the buddy of each parent checked for full; a free reads and classifies the
// handle, clears each node, checks each buddy and reads each ancestor before the done state.
// Throughput: one item at a time, busy high until the strobe; the receiver cannot stall.
// Reset (arst_n low) clears totals, sets the level register to 10 and clears all 2048 RAM nodes.
// ----------------------------------------------------------------------------
// Buddy tree allocator
// Sequencer walking a binary tree of node states held in one RAM.
// ----------------------------------------------------------------------------
module buddy_tree_allocator_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bta_pkg::bta_in_t  in_item,
	output logic              done,
	output bta_pkg::bta_out_t result,
	input  logic              cfg_we,
	input  logic [3:0]        cfg_wdata
);
	import bta_pkg::*;

	localparam int AW    = MAX_LEVELS + 1;
	localparam int DEPTH = 1 << AW;
	localparam int LW    = $clog2(MAX_LEVELS + 2);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;
	localparam logic [3:0] S_AEV   = 4'd3;
	localparam logic [3:0] S_ASPL  = 4'd4;
	localparam logic [3:0] S_ASPR  = 4'd5;
	localparam logic [3:0] S_ACLM  = 4'd6;
	localparam logic [3:0] S_BRD   = 4'd7;
	localparam logic [3:0] S_UPEV  = 4'd8;
	localparam logic [3:0] S_FEV   = 4'd9;
	localparam logic [3:0] S_FMW   = 4'd10;
	localparam logic [3:0] S_FMBE  = 4'd11;
	localparam logic [3:0] S_FARD  = 4'd12;
	localparam logic [3:0] S_FAEV  = 4'd13;
	localparam logic [3:0] S_DONE  = 4'd14;

	logic [3:0]    state_q;
	logic [3:0]    levels_q;
	logic [AW-1:0] idx_q, node_q, aux_q, clr_q;
	logic [LW-1:0] depth_q, lv_q, tgt_q;
	logic          op_q;
	logic [10:0]   used_q, peak_q;
	logic [2:0]    st_q;
	bta_out_t      res_q;
	logic          done_q;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [1:0]    ram_wdata, ram_rdata;

	bta_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// Tree neighbours of the search node and of the walking node.
	logic [AW-1:0] idx_par, idx_left, idx_right, aux_par, aux_bud;
	assign idx_par   = (idx_q - AW'(1)) >> 1;
	assign idx_left  = {idx_q[AW-2:0], 1'b1};
	assign idx_right = idx_left + AW'(1);
	assign aux_par   = (aux_q - AW'(1)) >> 1;
	assign aux_bud   = aux_q[0] ? aux_q + AW'(1) : aux_q - AW'(1);

	logic [LW-1:0] lv_in;
	logic [LW-1:0] tgt_in;
	logic [LW-1:0] fdepth;
	logic          size_ok;
	logic          handle_ok;

	// Level in use, target depth L - ceil(log2 size), and depth of a handle to free.
	always_comb begin
		logic [AW-1:0] r;
		logic [AW:0]   n1;
		logic [LW-1:0] cl;
		lv_in = (int'(levels_q) < MAX_LEVELS) ? LW'(levels_q) : LW'(MAX_LEVELS);
		r = in_item.request_size - 11'd1;
		cl = '0;
		for (int b = 0; b < AW; b++) begin
			if (r[b]) cl = LW'(b + 1);
		end
		size_ok = (cl <= lv_in);
		tgt_in = lv_in - cl;
		n1 = {1'b0, in_item.node_index} + (AW + 1)'(1);
		fdepth = '0;
		for (int b = 1; b < AW + 1; b++) begin
			if (n1[b]) fdepth = LW'(b);
		end
		handle_ok = (fdepth <= lv_in);
	end

	// Offset and size of the block at node_q, depth_q.
	logic [LW-1:0] span_w;
	logic [AW-1:0] off_w;
	logic [10:0]   units_w;
	assign span_w  = lv_q - depth_q;
	assign off_w   = (node_q + AW'(1) - (AW'(1) << depth_q)) << span_w;
	assign units_w = 11'(1) << span_w;

	// Totals after the item, saturating at both ends.
	logic [11:0] sum_w;
	logic [10:0] used_nx, peak_nx;
	always_comb begin
		sum_w = {1'b0, used_q} + {1'b0, units_w};
		if (st_q != ST_OK) begin
			used_nx = used_q;
		end else if (op_q == OP_ALLOC) begin
			used_nx = sum_w[11] ? 11'h7FF : sum_w[10:0];
		end else begin
			used_nx = (used_q > units_w) ? used_q - units_w : 11'd0;
		end
		peak_nx = (used_nx > peak_q) ? used_nx : peak_q;
	end

	// RAM port control.
	always_comb begin
		ram_we = 1'b0;
		ram_addr = idx_q;
		ram_wdata = BLK_VACANT;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_addr = clr_q;
			end
			S_AEV: begin
				if (ram_rdata == BLK_VACANT) begin
					ram_we = 1'b1;
					ram_wdata = (depth_q == tgt_q) ? BLK_TAKEN : BLK_HALVED;
				end
			end
			S_ASPL: begin
				ram_we = 1'b1;
				ram_addr = idx_left;
			end
			S_ASPR: begin
				ram_we = 1'b1;
				ram_addr = idx_right;
			end
			S_BRD: ram_addr = aux_bud;
			S_UPEV: begin
				if (ram_rdata == BLK_TAKEN || ram_rdata == BLK_PACKED) begin
					ram_we = 1'b1;
					ram_addr = aux_par;
					ram_wdata = BLK_PACKED;
				end
			end
			S_FMW: begin
				ram_we = 1'b1;
				ram_addr = aux_q;
			end
			S_FARD: ram_addr = aux_par;
			S_FAEV: begin
				ram_addr = aux_q;
				if (ram_rdata == BLK_PACKED) begin
					ram_we = 1'b1;
					ram_wdata = BLK_HALVED;
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = res_q;

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			levels_q <= 4'd10;
			clr_q    <= '0;
			used_q   <= '0;
			peak_q   <= '0;
			done_q   <= 1'b0;
			idx_q    <= '0;
			node_q   <= '0;
			aux_q    <= '0;
			depth_q  <= '0;
			lv_q     <= '0;
			tgt_q    <= '0;
			op_q     <= 1'b0;
			st_q     <= ST_OK;
			res_q    <= '0;
		end else begin
			if (cfg_we) begin
				levels_q <= cfg_wdata;
			end
			done_q <= (state_q == S_DONE);
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						op_q <= in_item.operation;
						lv_q <= lv_in;
						if (in_item.operation == OP_ALLOC) begin
							idx_q <= '0;
							depth_q <= '0;
							tgt_q <= tgt_in;
							if (in_item.request_size == 11'd0) begin
								st_q <= ST_ZERO;
								state_q <= S_DONE;
							end else if (!size_ok) begin
								st_q <= ST_NOMEM;
								state_q <= S_DONE;
							end else begin
								st_q <= ST_OK;
								state_q <= S_RD;
							end
						end else begin
							idx_q <= in_item.node_index;
							node_q <= in_item.node_index;
							aux_q <= in_item.node_index;
							depth_q <= fdepth;
							if (!handle_ok) begin
								st_q <= ST_BADHANDLE;
								state_q <= S_DONE;
							end else begin
								st_q <= ST_OK;
								state_q <= S_RD;
							end
						end
					end
				end
				S_RD: state_q <= (op_q == OP_ALLOC) ? S_AEV : S_FEV;
				S_AEV: begin
					// Take, split, descend into a split node, or move on.
					if (depth_q == tgt_q && ram_rdata == BLK_VACANT) begin
						node_q <= idx_q;
						aux_q <= idx_q;
						state_q <= (idx_q == '0) ? S_DONE : S_BRD;
					end else if (depth_q != tgt_q && ram_rdata == BLK_VACANT) begin
						state_q <= S_ASPL;
					end else if (depth_q != tgt_q && ram_rdata == BLK_HALVED) begin
						idx_q <= idx_left;
						depth_q <= depth_q + LW'(1);
						state_q <= S_RD;
					end else if (idx_q[0]) begin
						idx_q <= idx_q + AW'(1);
						state_q <= S_RD;
					end else begin
						state_q <= S_ACLM;
					end
				end
				S_ASPL: state_q <= S_ASPR;
				S_ASPR: begin
					idx_q <= idx_left;
					depth_q <= depth_q + LW'(1);
					state_q <= S_RD;
				end
				S_ACLM: begin
					// Climb until a right sibling is left to try.
					if (idx_q == '0) begin
						st_q <= ST_NOMEM;
						state_q <= S_DONE;
					end else begin
						depth_q <= depth_q - LW'(1);
						if (idx_par[0]) begin
							idx_q <= idx_par + AW'(1);
							state_q <= S_RD;
						end else begin
							idx_q <= idx_par;
						end
					end
				end
				S_BRD: state_q <= (op_q == OP_ALLOC) ? S_UPEV : S_FMBE;
				S_UPEV: begin
					// Mark the parent full while the buddy is taken as well.
					if (ram_rdata == BLK_TAKEN || ram_rdata == BLK_PACKED) begin
						aux_q <= aux_par;
						state_q <= (aux_par == '0) ? S_DONE : S_BRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_FEV: begin
					// Free: classify the handle's state.
					if (ram_rdata == BLK_VACANT) begin
						st_q <= ST_FREED;
						state_q <= S_DONE;
					end else if (ram_rdata != BLK_TAKEN) begin
						st_q <= ST_NOTALLOC;
						state_q <= S_DONE;
					end else begin
						state_q <= S_FMW;
					end
				end
				S_FMW: state_q <= (aux_q == '0) ? S_DONE : S_BRD;
				S_FMBE: begin
					// Merge upward while the buddy is unused.
					if (ram_rdata == BLK_VACANT) begin
						aux_q <= aux_par;
						state_q <= S_FMW;
					end else begin
						state_q <= S_FARD;
					end
				end
				S_FARD: begin
					aux_q <= aux_par;
					state_q <= S_FAEV;
				end
				S_FAEV: begin
					// Full ancestors go back to split.
					if (ram_rdata == BLK_PACKED && aux_q != '0) begin
						state_q <= S_FARD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					used_q <= used_nx;
					peak_q <= peak_nx;
					res_q.status <= st_q;
					res_q.granted_node <= (st_q == ST_OK) ? node_q : '0;
					res_q.block_offset <= (st_q == ST_OK) ? off_w[9:0] : '0;
					res_q.block_units <= (st_q == ST_OK) ? units_w : '0;
					res_q.used_units <= used_nx;
					res_q.peak_units <= peak_nx;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Assertions.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than a cycle");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(start && !busy)) else $error("result without work");
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= used_q) else $error("peak below used total");
	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.block_units == 11'd0)
		else $error("error result carries a block");
endmodule

FILE: rtl/bta_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single port RAM
// One access per cycle, registered read data.
// ----------------------------------------------------------------------------
module bta_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Read first port: a write in the same cycle returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
